[design/assert_macros.svh]
// Assertion macros shared by the modular exponentiation RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/modexp_pkg.sv]
// Shared types for the modular exponentiation block.
// No dependencies; imported by modexp_mulmod and modular_exponentiation.
package modexp_pkg;

    // Status of the shared multiply-and-reduce unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

[design/modexp_mulmod.sv]
// Bit-serial modular multiplier: product of two residues reduced by a modulus.
// Depends on modexp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module modexp_mulmod import modexp_pkg::*; #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic [W-1:0] o_product,
    output t_mm_status   o_status
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_bsh;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_m;
    logic [W-1:0]  r_acc;

    logic [W+1:0]  sum;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W-1:0]  n_acc;

    // One multiplier bit per cycle, MSB first: acc = 2*acc + bit*a, then
    // reduce. The sum stays below 3*m, so at most 2*m is taken off.
    always_comb begin
        m1  = {2'b00, r_m};
        m2  = {1'b0, r_m, 1'b0};
        sum = {1'b0, r_acc, 1'b0} + (r_bsh[W-1] ? {2'b00, r_a} : '0);
        priority if (sum >= m2) begin
            n_acc = W'(sum - m2);
        end else if (sum >= m1) begin
            n_acc = W'(sum - m1);
        end else begin
            n_acc = sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
                r_bsh  <= i_b;
                r_a    <= i_a;
                r_m    <= i_m;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_bsh <= {r_bsh[W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_product     = r_acc;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    `ASSERT_CLK(a_acc_reduced, i_clk, i_rst_n, r_busy |-> (r_acc < r_m), "accumulator not reduced")
    `ASSERT_CLK(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy), "done without a run")
    `ASSERT_CLK(a_done_idle, i_clk, i_rst_n, r_done |-> !r_busy, "done while still running")

endmodule

[design/modular_exponentiation.sv]
// The multiplier runs once for the base reduction, once per set exponent bit and once per
// squaring, with one squaring per bit below the highest set one (no run at all for a
// modulus of zero or one).
// Throughput: one item at a time; the next item is taken once the result sits in the
// output register, which may still be waiting to be taken.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
//
// Modular exponentiation by right-to-left square-and-multiply. The base is first
// reduced modulo the modulus by running it through the multiplier with a unit addend,
// which amounts to a restoring remainder one bit per cycle. Each exponent bit, taken
// least significant first, then costs a multiply of the running result when set, and a
// squaring of the base when higher exponent bits remain. A modulus of zero or one skips
// all work and returns zero with the error flag raised. Depends on modexp_pkg,
// modexp_mulmod and assert_macros.svh.
`include "assert_macros.svh"

module modular_exponentiation import modexp_pkg::*; #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OPERAND_BITS-1:0] i_base_value,
    input  logic [OPERAND_BITS-1:0] i_exponent,
    input  logic [OPERAND_BITS-1:0] i_modulus,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OPERAND_BITS-1:0] o_power_result,
    output logic                    o_bad_modulus
);

    localparam int W = OPERAND_BITS;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_SQR    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [W-1:0] r_base, n_base;
    logic [W-1:0] r_exp, n_exp;
    logic [W-1:0] r_mod, n_mod;
    logic [W-1:0] r_res, n_res;
    logic         r_bad, n_bad;
    logic         r_out_valid;
    logic [W-1:0] r_out_power;
    logic         r_out_bad;

    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic [W-1:0] mm_m;
    logic [W-1:0] mm_product;
    t_mm_status   mm_status;

    logic         plan_go;
    logic [W-1:0] plan_e;
    logic [W-1:0] plan_base;
    logic         out_load;

    modexp_mulmod #(
        .W(W)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_a       (mm_a),
        .i_b       (mm_b),
        .i_m       (mm_m),
        .o_product (mm_product),
        .o_status  (mm_status)
    );

    // A finished result moves to the output register once that register is free
    // or its current transfer completes in this cycle.
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // The multiplier latches its modulus at start; the first start comes straight
    // from the input ports.
    assign mm_m = (r_state == S_IDLE) ? i_modulus : r_mod;

    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_exp     = r_exp;
        n_mod     = r_mod;
        n_res     = r_res;
        n_bad     = r_bad;
        mm_start  = 1'b0;
        mm_a      = r_res;
        mm_b      = r_base;
        plan_go   = 1'b0;
        plan_e    = r_exp;
        plan_base = r_base;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mod = i_modulus;
                    n_exp = i_exponent;
                    n_res = W'(1);
                    n_bad = 1'b0;
                    if (i_modulus < W'(2)) begin
                        n_res   = '0;
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        // Reduce the base: base * 1 mod m.
                        mm_start = 1'b1;
                        mm_a     = W'(1);
                        mm_b     = i_base_value;
                        n_state  = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mm_status.done) begin
                    n_base    = mm_product;
                    plan_go   = 1'b1;
                    plan_e    = r_exp;
                    plan_base = mm_product;
                end
            end
            S_MUL: begin
                if (mm_status.done) begin
                    n_res = mm_product;
                    if (r_exp[W-1:1] == '0) begin
                        n_state = S_DONE;
                    end else begin
                        mm_start = 1'b1;
                        mm_a     = r_base;
                        mm_b     = r_base;
                        n_state  = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mm_status.done) begin
                    n_base    = mm_product;
                    n_exp     = r_exp >> 1;
                    plan_go   = 1'b1;
                    plan_e    = r_exp >> 1;
                    plan_base = mm_product;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Work on the lowest remaining exponent bit. An exponent that has run out (or was zero
        // from the start) finishes; a set bit starts a multiply and a clear bit a squaring.
        if (plan_go) begin
            priority if (plan_e == '0) begin
                n_state = S_DONE;
            end else if (plan_e[0]) begin
                mm_start = 1'b1;
                mm_a     = r_res;
                mm_b     = plan_base;
                n_state  = S_MUL;
            end else begin
                mm_start = 1'b1;
                mm_a     = plan_base;
                mm_b     = plan_base;
                n_state  = S_SQR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_out_valid && i_stall) || out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_exp  <= n_exp;
        r_mod  <= n_mod;
        r_res  <= n_res;
        r_bad  <= n_bad;
        if (out_load) begin
            r_out_power <= r_res;
            r_out_bad   <= r_bad;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_power_result = r_out_power;
    assign o_bad_modulus  = r_out_bad;

    `ASSERT_CLK(a_bad_gives_zero, i_clk, i_rst_n, (o_valid && o_bad_modulus) |-> (o_power_result == '0), "error result is not zero")
    `ASSERT_CLK(a_unit_running, i_clk, i_rst_n, (r_state == S_REDUCE || r_state == S_MUL || r_state == S_SQR) |-> (mm_status.busy || mm_status.done), "waiting on an idle multiplier")
    `ASSERT_CLK(a_start_when_free, i_clk, i_rst_n, mm_start |-> !mm_status.busy, "multiplier restarted while running")

endmodule
